/* design/rfd_pkg.sv */
package rfd_pkg;

   // Default message buffer depth.
   localparam int MaxLenDefault = 64;

   localparam int DataWidth = 8;
   localparam int RailsWidth = 3;
   localparam int RailMin = 2;
   localparam int RailMax = 5;
   localparam logic [RailsWidth-1:0] RailsReset = RailsWidth'(2);

   // Configuration port geometry: one 32-bit register at byte address 0.
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;
   localparam logic RegRails = 1'b0;

   typedef enum logic [4:0] {
      ST_LOAD   = 5'b00001,
      ST_COUNT  = 5'b00010,
      ST_PREFIX = 5'b00100,
      ST_READ   = 5'b01000,
      ST_SEND   = 5'b10000
   } state_type;

   // Clamp the programmed rail count into the supported range.
   function automatic logic [RailsWidth-1:0] eff_rails(input logic [RailsWidth-1:0] rails);
      logic [RailsWidth-1:0] result;
      result = rails;
      if (rails < RailsWidth'(RailMin)) begin
         result = RailsWidth'(RailMin);
      end else if (rails > RailsWidth'(RailMax)) begin
         result = RailsWidth'(RailMax);
      end
      return result;
   endfunction

endpackage

/* design/rfd_csr.sv */
module rfd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rfd_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [rfd_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [rfd_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                csr_pready,
   output logic [rfd_pkg::RailsWidth-1:0]      rails
);

   logic [rfd_pkg::RailsWidth-1:0] rails_ff;
   logic [rfd_pkg::RailsWidth-1:0] rails_in;
   logic                           wr_hit;

   // The word index is the address bit above the byte offset.
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == rfd_pkg::RegRails);

   always_comb begin
      rails_in = rails_ff;
      if (wr_hit) begin
         rails_in = csr_pwdata[rfd_pkg::RailsWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rails_ff <= rfd_pkg::RailsReset;
      end else begin
         rails_ff <= rails_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == rfd_pkg::RegRails) begin
         csr_prdata = rfd_pkg::CsrDataWidth'(rails_ff);
      end
   end

   assign csr_pready = 1'b1;
   assign rails = rails_ff;

endmodule

/* design/rfd_store.sv */
module rfd_store #(
   parameter int Depth = rfd_pkg::MaxLenDefault,
   parameter int AddrWidth = $clog2(Depth)
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [AddrWidth-1:0]           wr_addr,
   input  logic [rfd_pkg::DataWidth-1:0]  wr_data,
   input  logic                           rd_en,
   input  logic [AddrWidth-1:0]           rd_addr,
   output logic [rfd_pkg::DataWidth-1:0]  rd_data
);

   logic [rfd_pkg::DataWidth-1:0] mem_ff [Depth];
   logic [rfd_pkg::DataWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data is held until the next read, so a stalled beat stays put.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/rfd_seq.sv */
module rfd_seq #(
   parameter int MaxLen = rfd_pkg::MaxLenDefault,
   parameter int AddrWidth = $clog2(MaxLen),
   parameter int CntWidth = $clog2(MaxLen + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [rfd_pkg::RailsWidth-1:0]    rails,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic                              rsp_tlast,
   output logic                              wr_en,
   output logic [AddrWidth-1:0]              wr_addr,
   output logic                              rd_en,
   output logic [AddrWidth-1:0]              rd_addr
);

   localparam int RowWidth = rfd_pkg::RailsWidth;

   rfd_pkg::state_type state_ff, state_in;

   logic [CntWidth-1:0] load_cnt_ff, load_cnt_in;
   logic [CntWidth-1:0] n_ff, n_in;
   logic [CntWidth-1:0] col_ff, col_in;
   logic [CntWidth-1:0] acc_ff, acc_in;
   logic [RowWidth-1:0] row_ff, row_in;
   logic [RowWidth-1:0] k_ff, k_in;
   logic                down_ff, down_in;
   logic                last_ff, last_in;
   // Per-rail length during the count pass, then per-rail read pointer.
   logic [CntWidth-1:0] rail_ff [rfd_pkg::RailMax];
   logic [CntWidth-1:0] rail_in [rfd_pkg::RailMax];

   logic [CntWidth-1:0] add_a, add_b, add_sum;
   logic [CntWidth-1:0] col_next;
   logic [RowWidth-1:0] row_next;
   logic                down_next;
   logic                has_room;

   // The one shared adder: rail lengths, running prefix and pointer bumps.
   always_comb begin
      if (state_ff == rfd_pkg::ST_PREFIX) begin
         add_a = acc_ff;
         add_b = rail_ff[row_ff];
      end else begin
         add_a = rail_ff[row_ff];
         add_b = CntWidth'(1);
      end
      add_sum = add_a + add_b;
   end

   // Zigzag step: turn at the top and bottom rails.
   always_comb begin
      down_next = down_ff;
      if (row_ff == '0) begin
         down_next = 1'b1;
      end else if (row_ff == k_ff - RowWidth'(1)) begin
         down_next = 1'b0;
      end
      row_next = down_next ? row_ff + RowWidth'(1) : row_ff - RowWidth'(1);
   end

   assign col_next = col_ff + CntWidth'(1);
   assign has_room = (load_cnt_ff < CntWidth'(MaxLen));

   always_comb begin
      state_in = state_ff;
      load_cnt_in = load_cnt_ff;
      n_in = n_ff;
      col_in = col_ff;
      acc_in = acc_ff;
      row_in = row_ff;
      k_in = k_ff;
      down_in = down_ff;
      last_in = last_ff;
      rail_in = rail_ff;
      wr_en = 1'b0;
      rd_en = 1'b0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;

      unique case (state_ff)
         rfd_pkg::ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (has_room) begin
                  wr_en = 1'b1;
                  load_cnt_in = load_cnt_ff + CntWidth'(1);
               end
               if (req_tlast) begin
                  n_in = has_room ? load_cnt_ff + CntWidth'(1) : load_cnt_ff;
                  load_cnt_in = '0;
                  k_in = rfd_pkg::eff_rails(rails);
                  row_in = '0;
                  down_in = 1'b1;
                  col_in = '0;
                  for (int r = 0; r < rfd_pkg::RailMax; r++) begin
                     rail_in[r] = '0;
                  end
                  state_in = rfd_pkg::ST_COUNT;
               end
            end
         end
         rfd_pkg::ST_COUNT: begin
            rail_in[row_ff] = add_sum;
            row_in = row_next;
            down_in = down_next;
            col_in = col_next;
            if (col_next == n_ff) begin
               row_in = '0;
               acc_in = '0;
               state_in = rfd_pkg::ST_PREFIX;
            end
         end
         rfd_pkg::ST_PREFIX: begin
            rail_in[row_ff] = acc_ff;
            acc_in = add_sum;
            if (row_ff == RowWidth'(rfd_pkg::RailMax - 1)) begin
               row_in = '0;
               down_in = 1'b1;
               col_in = '0;
               state_in = rfd_pkg::ST_READ;
            end else begin
               row_in = row_ff + RowWidth'(1);
            end
         end
         rfd_pkg::ST_READ: begin
            rd_en = 1'b1;
            rail_in[row_ff] = add_sum;
            last_in = (col_next == n_ff);
            row_in = row_next;
            down_in = down_next;
            state_in = rfd_pkg::ST_SEND;
         end
         rfd_pkg::ST_SEND: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (last_ff) begin
                  state_in = rfd_pkg::ST_LOAD;
               end else begin
                  col_in = col_next;
                  state_in = rfd_pkg::ST_READ;
               end
            end
         end
         default: begin
            state_in = rfd_pkg::ST_LOAD;
         end
      endcase
   end

   assign wr_addr = load_cnt_ff[AddrWidth-1:0];
   assign rd_addr = rail_ff[row_ff][AddrWidth-1:0];
   assign rsp_tlast = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rfd_pkg::ST_LOAD;
         load_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         load_cnt_ff <= load_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      col_ff <= col_in;
      acc_ff <= acc_in;
      row_ff <= row_in;
      k_ff <= k_in;
      down_ff <= down_in;
      last_ff <= last_in;
      rail_ff <= rail_in;
   end

   a_load_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      load_cnt_ff <= CntWidth'(MaxLen))
      else $error("load count beyond buffer depth");

   a_count_col_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rfd_pkg::ST_COUNT) |-> (col_ff < n_ff))
      else $error("count pass ran past message length");

   a_row_in_fence: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rfd_pkg::ST_COUNT || state_ff == rfd_pkg::ST_READ) |-> (row_ff < k_ff))
      else $error("zigzag row outside rail count");

   a_ptr_in_message: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rfd_pkg::ST_READ) |-> (rail_ff[row_ff] < n_ff))
      else $error("rail pointer beyond message");

   a_last_ends_message: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=>
         (state_ff == rfd_pkg::ST_LOAD && load_cnt_ff == '0))
      else $error("block not empty after final beat");

endmodule

/* design/rail_fence_decrypt_unit.sv */
// Rail fence cipher decryption.
// The req channel takes ciphertext one byte per beat in rail-by-rail order;
// req_tlast marks the final byte of a message. Bytes that arrive while the
// buffer already holds MAX_LEN bytes are dropped. Loading gives no output.
// After the last beat the block stops taking beats and decrypts: it walks
// the zigzag once to count the bytes on each rail, turns the counts into
// start pointers for all five rail slots, then walks the zigzag again,
// reading one byte from the buffer and presenting it on rsp. The rail
// counts, prefix sums and pointer bumps all go through one shared adder,
// and the buffer has a single registered read port, so each plaintext
// byte takes a read step and then a send step.
// rsp_tlast marks the final plaintext beat, after which req_tready returns.
// If the receiver holds rsp_tready low, the current beat stays on rsp and
// the block waits. Reset empties the buffer and sets the rail count to two.
// The user writes the rail count over the csr port between messages; the
// block does not enforce this. Values below two act as two and values above five act as five.
module rail_fence_decrypt_unit #(
   parameter int MAX_LEN = rfd_pkg::MaxLenDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   // Ciphertext channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] cipher_byte
   input  logic                              req_tlast,  // is_last
   // Plaintext channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,  // [7:0] plain_byte
   output logic                              rsp_tlast,  // last_out
   // Configuration port; rails lies at byte address 0.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rfd_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [rfd_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [rfd_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready
);

   localparam int AddrWidth = $clog2(MAX_LEN);
   localparam int CntWidth = $clog2(MAX_LEN + 1);

   logic [rfd_pkg::RailsWidth-1:0] rails;
   logic                           wr_en;
   logic [AddrWidth-1:0]           wr_addr;
   logic                           rd_en;
   logic [AddrWidth-1:0]           rd_addr;

   rfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .rails       (rails)
   );

   // Message buffer: written in arrival order, read in zigzag order.
   rfd_store #(
      .Depth     (MAX_LEN),
      .AddrWidth (AddrWidth)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rsp_tdata)
   );

   // Sequencer with the shared adder and the per-rail pointers.
   rfd_seq #(
      .MaxLen    (MAX_LEN),
      .AddrWidth (AddrWidth),
      .CntWidth  (CntWidth)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .rails      (rails),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr)
   );

endmodule

/* tb/sv/rail_fence_decrypt_unit_tb.sv */
`timescale 1ns / 100ps

// One plaintext beat as the block should present it.
typedef struct packed {
   logic [7:0] data;
   logic       last;
} plain_beat_type;

// Tracks the ciphertext held by the block and the rail count, and works out
// the plaintext of each message when its last byte is accepted.
class plaintext_predictor;
   localparam int MsgDepth = rfd_pkg::MaxLenDefault;

   logic [7:0]                      held_bytes[MsgDepth];
   int                              held_count;
   logic [rfd_pkg::RailsWidth-1:0]  rails;
   plain_beat_type                  expected_plain[$];
   int                              errors;
   int                              checked;

   function new();
      held_count = 0;
      rails = rfd_pkg::RailsReset;
      errors = 0;
      checked = 0;
   endfunction

   function void set_rails(logic [rfd_pkg::RailsWidth-1:0] value);
      rails = value;
   endfunction

   // Moves one step along the zigzag, turning at the top and bottom rails.
   function int next_rail(int row, ref bit heading_down, input int depth);
      if (row == 0) begin
         heading_down = 1'b1;
      end else if (row == depth - 1) begin
         heading_down = 1'b0;
      end
      return heading_down ? row + 1 : row - 1;
   endfunction

   function void take_cipher_byte(logic [7:0] value, logic is_final);
      int             depth;
      int             row;
      int             pos;
      bit             heading_down;
      int             rail_len[rfd_pkg::RailMax];
      int             rail_base[rfd_pkg::RailMax];
      int             rail_used[rfd_pkg::RailMax];
      plain_beat_type beat;

      // Bytes beyond the buffer depth are dropped.
      if (held_count < MsgDepth) begin
         held_bytes[held_count] = value;
         held_count++;
      end
      if (!is_final) begin
         return;
      end

      if (rails < rfd_pkg::RailMin) begin
         depth = rfd_pkg::RailMin;
      end else if (rails > rfd_pkg::RailMax) begin
         depth = rfd_pkg::RailMax;
      end else begin
         depth = rails;
      end

      foreach (rail_len[r]) begin
         rail_len[r] = 0;
         rail_used[r] = 0;
      end

      // First pass: how many zigzag positions land on each rail.
      row = 0;
      heading_down = 1'b1;
      for (int col = 0; col < held_count; col++) begin
         rail_len[row]++;
         row = next_rail(row, heading_down, depth);
      end

      rail_base[0] = 0;
      for (int r = 1; r < rfd_pkg::RailMax; r++) begin
         rail_base[r] = rail_base[r-1] + rail_len[r-1];
      end

      // Second pass: read each rail in turn along the zigzag.
      row = 0;
      heading_down = 1'b1;
      for (int col = 0; col < held_count; col++) begin
         pos = rail_base[row] + rail_used[row];
         rail_used[row]++;
         beat.data = held_bytes[pos];
         beat.last = (col == held_count - 1);
         expected_plain = {expected_plain, beat};
         row = next_rail(row, heading_down, depth);
      end
      held_count = 0;
   endfunction

   function void check_plain_byte(logic [7:0] data, logic last);
      plain_beat_type want;

      if (expected_plain.size() == 0) begin
         errors++;
         $display("%0t: plaintext beat with nothing pending: data %h last %b",
                  $time, data, last);
         return;
      end
      want = expected_plain.pop_front();
      checked++;
      if (data !== want.data) begin
         errors++;
         $display("%0t: plain_byte mismatch: expected %h, actual %h",
                  $time, want.data, data);
      end
      if (last !== want.last) begin
         errors++;
         $display("%0t: last_out mismatch: expected %b, actual %b",
                  $time, want.last, last);
      end
   endfunction

   function bit idle();
      return expected_plain.size() == 0;
   endfunction
endclass

// Testbench for the rail fence decryption unit. Ciphertext messages are
// streamed into the req channel with random gaps while the rsp channel is
// stalled at random; every plaintext beat is checked in order against a
// predictor that holds its own copy of the buffer and the rail count. The
// rail count is reprogrammed between messages, including values outside the
// supported range, and read back over the csr port after each write.
module rail_fence_decrypt_unit_tb;
   localparam int MsgDepth = rfd_pkg::MaxLenDefault;

   // The rail count is register zero of the csr map.
   localparam logic [rfd_pkg::CsrAddrWidth-1:0] RailsAddr =
      rfd_pkg::CsrAddrWidth'(4 * rfd_pkg::RegRails);

   // Cycles to let pass after the last plaintext beat before touching the
   // csr port or ending the run; the block is back in loading once that beat
   // is taken.
   localparam int SettleCycles = 12;

   localparam int PhaseBeats = 50;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] cipher_byte
   logic        req_tlast = 1'b0; // is_last

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [7:0] plain_byte
   logic        rsp_tlast;        // last_out

   logic                               csr_psel = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite = 1'b0;
   logic [rfd_pkg::CsrAddrWidth-1:0]   csr_paddr = '0;
   logic [rfd_pkg::CsrDataWidth-1:0]   csr_pwdata = '0;
   logic [rfd_pkg::CsrDataWidth-1:0]   csr_prdata;
   logic                               csr_pready;

   plaintext_predictor predictor = new();

   // When set, neither side inserts idle cycles.
   bit quiet = 1'b0;
   int stall_left = 0;
   int readback_errors = 0;
   int messages_sent = 0;
   int overflow_messages = 0;
   int beats_sent = 0;
   int rail_writes = 0;

   always #10 clock = ~clock;

   rail_fence_decrypt_unit #(
      .MAX_LEN(MsgDepth)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Plaintext side. A beat moves at an edge where tvalid and tready were
   // both high just before it, so the check looks at the values sampled at
   // the edge, and the next tready is scheduled for after it. Stalls come in
   // random bursts.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         predictor.check_plain_byte(rsp_tdata, rsp_tlast);
      end
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Offers one ciphertext byte and returns once it has been taken. tvalid
   // stays high into the next call, so back-to-back bytes need no gap; an
   // idle burst, when one is drawn, comes before the byte is offered.
   task automatic send_cipher(input logic [7:0] value, input logic is_final);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tlast <= is_final;
      do @(posedge clock); while (!req_tready);
      predictor.take_cipher_byte(value, is_final);
      beats_sent++;
   endtask

   // A whole message: random bytes, or an ascending run of letters that
   // makes a wrong permutation easy to spot in the log.
   task automatic send_message(input int length, input bit random_bytes);
      logic [7:0] value;

      for (int i = 0; i < length; i++) begin
         value = random_bytes ? 8'($urandom_range(0, 255)) : 8'(8'h41 + i);
         send_cipher(value, i == length - 1);
      end
      messages_sent++;
      if (length > MsgDepth) begin
         overflow_messages++;
      end
   endtask

   // Drops tvalid and waits until every expected plaintext beat has come
   // back, then lets SettleCycles pass so the block is back in loading.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (!predictor.idle()) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Writes the rail count with random upper bits, then reads it back. Only
   // the low three bits are kept by the register.
   task automatic program_rails(input logic [rfd_pkg::RailsWidth-1:0] value);
      logic [rfd_pkg::CsrDataWidth-1:0] word;
      logic [rfd_pkg::CsrDataWidth-1:0] want;

      word = $urandom;
      word[rfd_pkg::RailsWidth-1:0] = value;
      want = rfd_pkg::CsrDataWidth'(value);

      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= RailsAddr;
      csr_pwdata <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      predictor.set_rails(value);
      rail_writes++;

      // Read back: a fresh setup cycle with psel still high.
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         readback_errors++;
         $display("%0t: rails readback mismatch: expected %h, actual %h",
                  $time, want, csr_prdata);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      logic [rfd_pkg::RailsWidth-1:0] phase_rails[10];
      int phase_start;
      int length;

      phase_rails = '{3'd2, 3'd5, 3'd3, 3'd6, 3'd4, 3'd0, 3'd1, 3'd7, 3'd0, 3'd0};
      phase_rails[5] = 3'($urandom_range(0, 7));
      phase_rails[8] = 3'($urandom_range(0, 7));
      phase_rails[9] = 3'($urandom_range(2, 5));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, starting on the reset rail count of two. A one-byte
      // message gives a single beat that is also the last one; the short
      // messages then cover both byte extremes.
      send_cipher(8'hFF, 1'b1);
      send_cipher(8'h00, 1'b0);
      send_cipher(8'hFF, 1'b0);
      send_cipher(8'hA5, 1'b1);
      drain();

      // Below the range: zero must behave like two rails.
      program_rails(3'd0);
      send_message(5, 1'b0);
      drain();

      // Above the range: seven must behave like five. Nine bytes take the
      // zigzag down and back up to the top rail.
      program_rails(3'd7);
      send_message(9, 1'b0);
      drain();

      // One rail is also clamped up to two.
      program_rails(3'd1);
      send_message(2, 1'b0);
      drain();

      // Random part. Each phase runs on one rail count; most messages are
      // short, some run up to one byte under the buffer depth, and a few
      // reach or run past it; surplus bytes are dropped. The last two phases
      // run with no idle cycles on either side.
      foreach (phase_rails[p]) begin
         if (p >= 8) begin
            quiet = 1'b1;
         end
         program_rails(phase_rails[p]);
         phase_start = beats_sent;
         while (beats_sent - phase_start < PhaseBeats) begin
            case ($urandom_range(0, 9))
               0: begin
                  length = $urandom_range(MsgDepth, MsgDepth + 8);
               end
               1: begin
                  length = $urandom_range(25, MsgDepth - 1);
               end
               default: begin
                  length = $urandom_range(1, 24);
               end
            endcase
            send_message(length, 1'b1);
         end
         drain();
      end

      $display("Sent %0d ciphertext beats in %0d messages (%0d longer than the buffer),",
               beats_sent, messages_sent, overflow_messages);
      $display("checked %0d plaintext beats over %0d rail count writes.",
               predictor.checked, rail_writes);
      if (predictor.errors == 0 && readback_errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog: a correct run ends well inside this.
   initial begin
      #5ms;
      $display("Timeout with %0d plaintext beats still pending.",
               predictor.expected_plain.size());
      $display("Some tests failed");
      $finish;
   end
endmodule
